/* rtl/core/lrlh_pkg.sv */
// ---------------------------------------------------------------------------
// lrlh_pkg
// Shared constants, codes and types for the least-relative-load heap
// scheduler core.
// ---------------------------------------------------------------------------
package lrlh_pkg;

  localparam int TARGETS   = 16;
  localparam int LOAD_BITS = 16;
  localparam int IDX_W     = $clog2(TARGETS);
  localparam int CNT_W     = $clog2(TARGETS + 1);
  localparam int GRP_W     = LOAD_BITS + IDX_W;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 3;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_GACQ   = 3'd3,
    CMD_TACQ   = 3'd4,
    CMD_REL    = 3'd5
  } cmd_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOCAP   = 3'd1,
    ST_EXISTS  = 3'd2,
    ST_NOTMEM  = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  // per-target record
  typedef struct packed {
    logic [LOAD_BITS-1:0] cur;
    logic [LOAD_BITS-1:0] max;
  } rec_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RM_SLOT,
    S_RM_REC,
    S_GA_REC,
    S_UP_CHK,
    S_UP_SLOT,
    S_UP_REC,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_SLOT,
    S_DN_REC,
    S_DN_SEL,
    S_DN_CMP
  } state_t;

endpackage

/* rtl/core/least_relative_load_heap_scheduler_core.sv */
// ---------------------------------------------------------------------------
// least_relative_load_heap_scheduler_core
// Weighted least-connections scheduler: member targets kept in a binary
// min-heap by relative load, compared by cross-multiplication. Heap slots,
// heap positions and target records live in synchronous memories.
// ---------------------------------------------------------------------------
// sequence: the result strobe is registered after the decode state for commands with no heap
//   move; each sift-up level takes slot read, record read, multiply and compare steps, each
//   sift-down level slot read, record read, child multiply, select and multiply, and compare
// throughput: one command at a time, busy stays high until the result strobe
// reset: synchronous active-low, clears loads, capacities, membership and group
//   sums at once through per-entry valid bits; no clearing pass
module least_relative_load_heap_scheduler_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lrlh_pkg::CMD_W-1:0]        in_command,
  input  logic [lrlh_pkg::IDX_W-1:0]        in_target_id,
  input  logic [lrlh_pkg::LOAD_BITS-1:0]    in_capacity,
  input  logic                              in_has_idle,
  output logic                              out_valid,
  output logic [lrlh_pkg::STAT_W-1:0]       out_status,
  output logic [lrlh_pkg::IDX_W-1:0]        out_chosen_target,
  output logic [lrlh_pkg::LOAD_BITS-1:0]    out_target_load
);
  import lrlh_pkg::*;

  localparam int IW2 = IDX_W + 2;
  localparam int PW  = 2 * LOAD_BITS;

  // memories
  logic [IDX_W-1:0] heap_mem [TARGETS];
  logic [IDX_W-1:0] pos_mem  [TARGETS];
  rec_t             rec_mem  [TARGETS];

  // memory ports
  logic             place_we;
  logic [IDX_W-1:0] place_idx, place_id;
  logic             rec_we;
  logic [IDX_W-1:0] rec_wa;
  rec_t             rec_wd;
  logic [IDX_W-1:0] heap_ra0, heap_ra1, rec_ra0, rec_ra1, pos_ra;
  logic [IDX_W-1:0] heap_rd0_r, heap_rd1_r, pos_rd_r;
  rec_t             rec_rd0_r, rec_rd1_r;
  logic             rv0_r, rv1_r;

  // control and datapath registers
  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [IDX_W-1:0]     tid_r, tid_nxt;
  logic [LOAD_BITS-1:0] cap_r, cap_nxt;
  logic                 idle_r, idle_nxt;
  logic                 swap_eq_r, swap_eq_nxt;
  logic                 down_after_r, down_after_nxt;
  logic [IDX_W-1:0]     id_r, id_nxt;
  rec_t                 idrec_r, idrec_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [IDX_W-1:0]     rm_idx_r, rm_idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [GRP_W-1:0]     gcur_r, gcur_nxt;
  logic [GRP_W-1:0]     gmax_r, gmax_nxt;
  logic [TARGETS-1:0]   member_r, member_nxt;
  logic [TARGETS-1:0]   valid_r, valid_nxt;
  logic [IDX_W-1:0]     c0_id_r, c0_id_nxt, c1_id_r, c1_id_nxt;
  rec_t                 c0_r, c0_nxt, c1_r, c1_nxt;
  logic                 single_r, single_nxt;
  logic [IDX_W-1:0]     i_r, i_nxt;
  logic [IDX_W-1:0]     m_id_r, m_id_nxt;
  logic [IDX_W-1:0]     m_idx_r, m_idx_nxt;
  logic [PW-1:0]        prodl_r, prodr_r;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [IDX_W-1:0]     chosen_r, chosen_nxt;
  logic [LOAD_BITS-1:0] load_r, load_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // combinational helpers
  rec_t                 rd0, rd1, opa, opb, msel;
  logic                 pick_c1;
  logic [IW2-1:0]       i_w, last_w;
  logic [IDX_W-1:0]     par;
  logic                 cmp_lt, cmp_le;

  // heap slot and position memories, written together by a place
  always_ff @(posedge clk) begin
    if (place_we) begin
      heap_mem[place_idx] <= place_id;
      pos_mem[place_id]   <= place_idx;
    end
    heap_rd0_r <= heap_mem[heap_ra0];
    heap_rd1_r <= heap_mem[heap_ra1];
    pos_rd_r   <= pos_mem[pos_ra];
  end

  // target record memory
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    rec_rd0_r <= rec_mem[rec_ra0];
    rec_rd1_r <= rec_mem[rec_ra1];
    rv0_r     <= valid_r[rec_ra0];
    rv1_r     <= valid_r[rec_ra1];
  end

  // never-written records read as zero
  assign rd0 = rv0_r ? rec_rd0_r : '0;
  assign rd1 = rv1_r ? rec_rd1_r : '0;

  // shared cross-multiply unit, products registered
  always_ff @(posedge clk) begin
    prodl_r <= PW'(opa.cur) * PW'(opb.max);
    prodr_r <= PW'(opb.cur) * PW'(opa.max);
  end
  assign cmp_lt = prodl_r < prodr_r;
  assign cmp_le = prodl_r <= prodr_r;

  // heap index arithmetic
  assign i_w     = {1'b0, pos_r, 1'b1};
  assign last_w  = IW2'(cnt_r - 1'b1);
  assign par     = IDX_W'((pos_r - 1'b1) >> 1);
  assign pick_c1 = !single_r && cmp_lt;
  assign msel    = pick_c1 ? c1_r : c0_r;

  // state and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      gcur_r      <= '0;
      gmax_r      <= '0;
      member_r    <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      gcur_r      <= gcur_nxt;
      gmax_r      <= gmax_nxt;
      member_r    <= member_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    tid_r        <= tid_nxt;
    cap_r        <= cap_nxt;
    idle_r       <= idle_nxt;
    swap_eq_r    <= swap_eq_nxt;
    down_after_r <= down_after_nxt;
    id_r         <= id_nxt;
    idrec_r      <= idrec_nxt;
    pos_r        <= pos_nxt;
    rm_idx_r     <= rm_idx_nxt;
    c0_id_r      <= c0_id_nxt;
    c1_id_r      <= c1_id_nxt;
    c0_r         <= c0_nxt;
    c1_r         <= c1_nxt;
    single_r     <= single_nxt;
    i_r          <= i_nxt;
    m_id_r       <= m_id_nxt;
    m_idx_r      <= m_idx_nxt;
    status_r     <= status_nxt;
    chosen_r     <= chosen_nxt;
    load_r       <= load_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    tid_nxt        = tid_r;
    cap_nxt        = cap_r;
    idle_nxt       = idle_r;
    swap_eq_nxt    = swap_eq_r;
    down_after_nxt = down_after_r;
    id_nxt         = id_r;
    idrec_nxt      = idrec_r;
    pos_nxt        = pos_r;
    rm_idx_nxt     = rm_idx_r;
    cnt_nxt        = cnt_r;
    gcur_nxt       = gcur_r;
    gmax_nxt       = gmax_r;
    member_nxt     = member_r;
    valid_nxt      = valid_r;
    c0_id_nxt      = c0_id_r;
    c1_id_nxt      = c1_id_r;
    c0_nxt         = c0_r;
    c1_nxt         = c1_r;
    single_nxt     = single_r;
    i_nxt          = i_r;
    m_id_nxt       = m_id_r;
    m_idx_nxt      = m_idx_r;
    status_nxt     = status_r;
    chosen_nxt     = chosen_r;
    load_nxt       = load_r;
    out_valid_nxt  = 1'b0;
    place_we       = 1'b0;
    place_idx      = pos_r;
    place_id       = id_r;
    rec_we         = 1'b0;
    rec_wa         = tid_r;
    rec_wd         = rd0;
    heap_ra0       = '0;
    heap_ra1       = '0;
    rec_ra0        = tid_r;
    rec_ra1        = '0;
    pos_ra         = tid_r;
    opa            = idrec_r;
    opb            = rd0;

    unique case (state_r)
      S_IDLE: begin
        // reads for the named target and the heap top go out with the transfer
        rec_ra0 = in_target_id;
        pos_ra  = in_target_id;
        if (start) begin
          cmd_nxt   = in_command;
          tid_nxt   = in_target_id;
          cap_nxt   = in_capacity;
          idle_nxt  = in_has_idle;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt     = ST_OK;
        chosen_nxt     = tid_r;
        load_nxt       = rd0.cur;
        id_nxt         = tid_r;
        pos_nxt        = pos_rd_r;
        swap_eq_nxt    = 1'b0;
        down_after_nxt = 1'b0;
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        unique case (cmd_r)
          CMD_INIT: begin
            if (cap_r == '0) begin
              status_nxt = ST_INVALID;
            end else if (member_r[tid_r]) begin
              status_nxt = ST_EXISTS;
            end else begin
              rec_we            = 1'b1;
              rec_wd.cur        = '0;
              rec_wd.max        = cap_r;
              valid_nxt[tid_r]  = 1'b1;
              load_nxt          = '0;
            end
          end
          CMD_ADD: begin
            if (member_r[tid_r]) begin
              status_nxt = ST_EXISTS;
            end else if (rd0.max == '0) begin
              status_nxt = ST_INVALID;
            end else begin
              pos_nxt           = cnt_r[IDX_W-1:0];
              cnt_nxt           = CNT_W'(cnt_r + 1'b1);
              member_nxt[tid_r] = 1'b1;
              gmax_nxt          = GRP_W'(gmax_r + GRP_W'(rd0.max));
              gcur_nxt          = GRP_W'(gcur_r + GRP_W'(rd0.cur));
              idrec_nxt         = rd0;
              out_valid_nxt     = 1'b0;
              state_nxt         = S_UP_CHK;
            end
          end
          CMD_REMOVE: begin
            if (!member_r[tid_r]) begin
              status_nxt = ST_NOTMEM;
            end else begin
              cnt_nxt           = CNT_W'(cnt_r - 1'b1);
              member_nxt[tid_r] = 1'b0;
              gmax_nxt          = GRP_W'(gmax_r - GRP_W'(rd0.max));
              gcur_nxt          = GRP_W'(gcur_r - GRP_W'(rd0.cur));
              // the last slot moves into the hole unless it is the hole
              if ({1'b0, pos_rd_r} != CNT_W'(cnt_r - 1'b1)) begin
                heap_ra0      = IDX_W'(cnt_r - 1'b1);
                rm_idx_nxt    = pos_rd_r;
                out_valid_nxt = 1'b0;
                state_nxt     = S_RM_SLOT;
              end
            end
          end
          CMD_GACQ: begin
            if (gcur_r >= gmax_r) begin
              status_nxt = ST_NOCAP;
              chosen_nxt = '0;
              load_nxt   = '0;
            end else begin
              rec_ra0       = heap_rd0_r;
              id_nxt        = heap_rd0_r;
              out_valid_nxt = 1'b0;
              state_nxt     = S_GA_REC;
            end
          end
          CMD_TACQ: begin
            if (rd0.cur >= rd0.max) begin
              status_nxt = ST_NOCAP;
            end else begin
              rec_we        = 1'b1;
              rec_wd.cur    = LOAD_BITS'(rd0.cur + 1'b1);
              load_nxt      = rec_wd.cur;
              idrec_nxt     = rec_wd;
              if (member_r[tid_r]) begin
                gcur_nxt      = GRP_W'(gcur_r + 1'b1);
                out_valid_nxt = 1'b0;
                state_nxt     = S_DN_CHK;
              end
            end
          end
          CMD_REL: begin
            if (rd0.cur == '0) begin
              status_nxt = ST_INVALID;
            end else begin
              rec_we        = 1'b1;
              rec_wd.cur    = LOAD_BITS'(rd0.cur - 1'b1);
              load_nxt      = rec_wd.cur;
              idrec_nxt     = rec_wd;
              if (member_r[tid_r]) begin
                gcur_nxt      = GRP_W'(gcur_r - 1'b1);
                swap_eq_nxt   = idle_r;
                out_valid_nxt = 1'b0;
                state_nxt     = S_UP_CHK;
              end
            end
          end
          default: begin
            status_nxt = ST_INVALID;
          end
        endcase
      end

      // remove: fetch the moved id and its record
      S_RM_SLOT: begin
        rec_ra0   = heap_rd0_r;
        id_nxt    = heap_rd0_r;
        state_nxt = S_RM_REC;
      end

      S_RM_REC: begin
        idrec_nxt      = rd0;
        pos_nxt        = rm_idx_r;
        swap_eq_nxt    = 1'b0;
        down_after_nxt = 1'b1;
        state_nxt      = S_UP_CHK;
      end

      // group acquire: bump the top's load, then sift it down
      S_GA_REC: begin
        rec_we     = 1'b1;
        rec_wa     = id_r;
        rec_wd.cur = LOAD_BITS'(rd0.cur + 1'b1);
        idrec_nxt  = rec_wd;
        gcur_nxt   = GRP_W'(gcur_r + 1'b1);
        pos_nxt    = '0;
        chosen_nxt = id_r;
        load_nxt   = rec_wd.cur;
        state_nxt  = S_DN_CHK;
      end

      // sift up: stop at the root or read the parent slot
      S_UP_CHK: begin
        if (pos_r == '0) begin
          place_we = 1'b1;
          if (down_after_r) begin
            state_nxt = S_DN_CHK;
          end else begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
          end
        end else begin
          heap_ra0  = par;
          state_nxt = S_UP_SLOT;
        end
      end

      S_UP_SLOT: begin
        rec_ra0   = heap_rd0_r;
        m_id_nxt  = heap_rd0_r;
        state_nxt = S_UP_REC;
      end

      // compare moving id against parent
      S_UP_REC: begin
        opa       = idrec_r;
        opb       = rd0;
        state_nxt = S_UP_CMP;
      end

      S_UP_CMP: begin
        place_we = 1'b1;
        if (swap_eq_r ? cmp_le : cmp_lt) begin
          place_id  = m_id_r;
          pos_nxt   = par;
          state_nxt = S_UP_CHK;
        end else if (down_after_r) begin
          state_nxt = S_DN_CHK;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end

      // sift down: read one or two children, or settle here
      S_DN_CHK: begin
        i_nxt    = i_w[IDX_W-1:0];
        heap_ra0 = i_w[IDX_W-1:0];
        heap_ra1 = IDX_W'(i_w + 1'b1);
        if (i_w < last_w) begin
          single_nxt = 1'b0;
          state_nxt  = S_DN_SLOT;
        end else if (i_w == last_w) begin
          single_nxt = 1'b1;
          state_nxt  = S_DN_SLOT;
        end else begin
          place_we      = 1'b1;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end

      S_DN_SLOT: begin
        c0_id_nxt = heap_rd0_r;
        c1_id_nxt = heap_rd1_r;
        rec_ra0   = heap_rd0_r;
        rec_ra1   = heap_rd1_r;
        state_nxt = S_DN_REC;
      end

      // compare right child against left child
      S_DN_REC: begin
        c0_nxt    = rd0;
        c1_nxt    = rd1;
        opa       = rd1;
        opb       = rd0;
        state_nxt = S_DN_SEL;
      end

      // take the smaller child and compare it against the moving id
      S_DN_SEL: begin
        m_id_nxt  = pick_c1 ? c1_id_r : c0_id_r;
        m_idx_nxt = pick_c1 ? IDX_W'(i_r + 1'b1) : i_r;
        opa       = msel;
        opb       = idrec_r;
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        place_we = 1'b1;
        if (cmp_lt) begin
          place_id  = m_id_r;
          pos_nxt   = m_idx_r;
          state_nxt = S_DN_CHK;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_chosen_target = chosen_r;
  assign out_target_load   = load_r;

endmodule
